// ----- design/dpf_pkg.sv -----
`default_nettype none

package dpf_pkg;

   // history size and field widths
   localparam int DPF_HISTORY_DEPTH = 64;
   localparam int DPF_BYTE_W        = 8;
   localparam int DPF_FP_W          = 2 * DPF_BYTE_W;

   // what one history cell hands to its neighbour
   typedef struct packed {
      logic                valid;
      logic [DPF_FP_W-1:0] fp;
   } dpf_link_type;

endpackage

`default_nettype wire

// ----- design/duplicate_payload_filter.sv -----
// Duplicate payload filter.
// Input channel: one payload byte per transfer on req_data_byte, with
// req_last_byte marking the final byte of a payload. Bytes at even positions
// fold by XOR into the low byte of a 16-bit fingerprint, odd positions into
// the high byte.
// Result channel: one transfer per payload carrying rsp_fingerprint and
// rsp_duplicate, set when the fingerprint matches one of the last
// HISTORY_DEPTH fingerprints stored. A new fingerprint is pushed into the
// row of history cells, pushing the oldest out; a duplicate is not stored.
// Throughput: one byte per cycle, payloads back to back, while req_stall is
// low. The result passes the probe register and then the output register;
// the history compare is one parallel match.
// Reset clears the lanes, the valid bits of the probe and output registers
// and every valid bit of the history, so nothing matches until it has been stored.
// When rsp_stall holds the output, the probe stage still fills; the input
// is stalled only when a probed fingerprint cannot move on.
`default_nettype none

module duplicate_payload_filter
   import dpf_pkg::*;
#(
   parameter int HISTORY_DEPTH = DPF_HISTORY_DEPTH
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [DPF_BYTE_W-1:0] req_data_byte,
   input  wire logic                  req_last_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [DPF_FP_W-1:0]   rsp_fingerprint,
   output logic                       rsp_duplicate
);

   logic                req_xfer;
   logic [DPF_FP_W-1:0] fp_next;
   logic                probe_valid_ff, probe_valid_in;
   logic [DPF_FP_W-1:0] probe_fp_ff, probe_fp_in;
   logic                probe_go;
   logic                any_hit;
   logic                push;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DPF_FP_W-1:0] rsp_fp_ff, rsp_fp_in;
   logic                rsp_dup_ff, rsp_dup_in;

   logic         [HISTORY_DEPTH-1:0] hit_vec;
   dpf_link_type [HISTORY_DEPTH:0]   link;

   // handshake
   always_comb begin
      probe_go  = probe_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall = probe_valid_ff && !probe_go;
      req_xfer  = req_valid && !req_stall;
   end

   // byte folding
   dpf_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .byte_xfer (req_xfer),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .fp_next   (fp_next)
   );

   // probe register holds a finished fingerprint
   always_comb begin
      probe_valid_in = probe_valid_ff && !probe_go;
      probe_fp_in    = probe_fp_ff;
      if (req_xfer && req_last_byte) begin
         probe_valid_in = 1'b1;
         probe_fp_in    = fp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_valid_ff <= 1'b0;
      end else begin
         probe_valid_ff <= probe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_fp_ff <= probe_fp_in;
   end

   // row of history cells, newest at the head
   assign link[0] = '{valid: 1'b1, fp: probe_fp_ff};

   always_comb begin
      any_hit = |hit_vec;
      push    = probe_go && !any_hit;
   end

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      dpf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (push),
         .link_prev (link[i]),
         .probe_fp  (probe_fp_ff),
         .link_next (link[i+1]),
         .hit       (hit_vec[i])
      );
   end

   // output register
   always_comb begin
      rsp_valid_in = probe_go || (rsp_valid_ff && rsp_stall);
      rsp_fp_in    = probe_go ? probe_fp_ff : rsp_fp_ff;
      rsp_dup_in   = probe_go ? any_hit : rsp_dup_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_fp_ff  <= rsp_fp_in;
      rsp_dup_ff <= rsp_dup_in;
   end

   always_comb begin
      rsp_valid       = rsp_valid_ff;
      rsp_fingerprint = rsp_fp_ff;
      rsp_duplicate   = rsp_dup_ff;
   end

endmodule

`default_nettype wire

// ----- design/dpf_fold.sv -----
`default_nettype none

module dpf_fold
   import dpf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  byte_xfer,
   input  wire logic [DPF_BYTE_W-1:0] data_byte,
   input  wire logic                  last_byte,
   output logic      [DPF_FP_W-1:0]   fp_next
);

   logic [DPF_BYTE_W-1:0] even_lane_ff, even_lane_in;
   logic [DPF_BYTE_W-1:0] odd_lane_ff, odd_lane_in;
   logic                  odd_pos_ff, odd_pos_in;
   logic [DPF_BYTE_W-1:0] even_fold;
   logic [DPF_BYTE_W-1:0] odd_fold;

   // fold the incoming byte into the lane of its position
   always_comb begin
      even_fold = odd_pos_ff ? even_lane_ff : (even_lane_ff ^ data_byte);
      odd_fold  = odd_pos_ff ? (odd_lane_ff ^ data_byte) : odd_lane_ff;
      fp_next   = {odd_fold, even_fold};
   end

   // lanes restart after the final byte
   always_comb begin
      even_lane_in = even_lane_ff;
      odd_lane_in  = odd_lane_ff;
      odd_pos_in   = odd_pos_ff;
      if (byte_xfer) begin
         if (last_byte) begin
            even_lane_in = '0;
            odd_lane_in  = '0;
            odd_pos_in   = 1'b0;
         end else begin
            even_lane_in = even_fold;
            odd_lane_in  = odd_fold;
            odd_pos_in   = ~odd_pos_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         even_lane_ff <= '0;
         odd_lane_ff  <= '0;
         odd_pos_ff   <= 1'b0;
      end else begin
         even_lane_ff <= even_lane_in;
         odd_lane_ff  <= odd_lane_in;
         odd_pos_ff   <= odd_pos_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/dpf_cell.sv -----
`default_nettype none

module dpf_cell
   import dpf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                shift,
   input  wire dpf_link_type        link_prev,
   input  wire logic [DPF_FP_W-1:0] probe_fp,
   output dpf_link_type             link_next,
   output logic                     hit
);

   logic                valid_ff, valid_in;
   logic [DPF_FP_W-1:0] fp_ff, fp_in;

   // take the neighbour's entry when a new fingerprint is pushed in
   always_comb begin
      valid_in = shift ? link_prev.valid : valid_ff;
      fp_in    = shift ? link_prev.fp : fp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fp_ff <= fp_in;
   end

   // local compare against the probed fingerprint
   always_comb begin
      hit             = valid_ff && (fp_ff == probe_fp);
      link_next.valid = valid_ff;
      link_next.fp    = fp_ff;
   end

endmodule

`default_nettype wire

// ----- design/dpf_checker.sv -----
`default_nettype none

module dpf_checker
   import dpf_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [DPF_FP_W-1:0]   rsp_fingerprint,
   input wire logic                  rsp_duplicate
);

   logic                rsp_xfer;
   logic                seen_ff, seen_in;
   logic [DPF_FP_W-1:0] prev_fp_ff, prev_fp_in;

   // last result fingerprint seen on the port
   always_comb begin
      rsp_xfer   = rsp_valid && !rsp_stall;
      seen_in    = seen_ff || rsp_xfer;
      prev_fp_in = rsp_xfer ? rsp_fingerprint : prev_fp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_fp_ff <= prev_fp_in;
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fingerprint)
                                 && $stable(rsp_duplicate))
      else $error("stalled result changed");

   // nothing to match before the first stored fingerprint
   a_first_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !seen_ff |-> !rsp_duplicate)
      else $error("first result after reset flagged duplicate");

   // the same fingerprint twice in a row is always a duplicate
   a_repeat_dup: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && seen_ff && (rsp_fingerprint == prev_fp_ff) |-> rsp_duplicate)
      else $error("repeated fingerprint not flagged");

   // input never stalls while the output register is empty
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // output empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind duplicate_payload_filter dpf_checker u_checker (.*);

`default_nettype wire
